FILE: sv/ocvsoc_pkg.sv
// Shared types, constants and helpers for the OCV to state-of-charge interpolator.
package ocvsoc_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int OCV_W      = 16;
  localparam int SOC_W      = 14;
  localparam int CFG_W      = 5;
  localparam int ENTRY_W    = OCV_W + SOC_W;
  localparam int PROD_W     = OCV_W + SOC_W;
  localparam int STEP_W     = $clog2(PROD_W);

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(MAX_POINTS);

  // Input word kinds
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  // Result range codes
  typedef enum logic [1:0] {
    RANGE_INTERP = 2'd0,
    RANGE_BELOW  = 2'd1,
    RANGE_ABOVE  = 2'd2
  } range_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_FIRST,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_MUL,
    S_DIV_GO,
    S_DIV
  } state_t;

  // Table read address select
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_ONE,
    RD_NEXT
  } rd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    wr_en;
    logic    query_go;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    save_lo;
    logic    save_hi;
    logic    idx_init;
    logic    idx_inc;
    logic    mul_go;
    logic    div_go;
    logic    emit;
    range_t  emit_range;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic below;
    logic at_top;
    logic div_done;
  } status_t;

  // Index of the last breakpoint in use, with the size saturated to 2..MAX_POINTS
  function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] ts);
    logic [IDX_W-1:0] res;
    if (ts < CFG_W'(2)) begin
      res = IDX_W'(1);
    end else if (int'(ts) > MAX_POINTS) begin
      res = IDX_W'(MAX_POINTS - 1);
    end else begin
      res = IDX_W'(ts - CFG_W'(1));
    end
    return res;
  endfunction

endpackage

FILE: sv/ocvsoc_div.sv
// Restoring serial divider, one quotient bit per cycle.
module ocvsoc_div
  import ocvsoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [OCV_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic              running;
  logic [STEP_W-1:0] cnt;
  logic [OCV_W-1:0]  rem;
  logic [OCV_W-1:0]  dsr;
  logic [OCV_W:0]    trial;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem, quotient[PROD_W-1]} - {1'b0, dsr};

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(PROD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Data: remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      if (!trial[OCV_W]) begin
        rem      <= trial[OCV_W-1:0];
        quotient <= {quotient[PROD_W-2:0], 1'b1};
      end else begin
        rem      <= {rem[OCV_W-2:0], quotient[PROD_W-1]};
        quotient <= {quotient[PROD_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/ocvsoc_ctrl.sv
// Control state machine: table search sequencing, divide handoff, result strobe.
module ocvsoc_ctrl
  import ocvsoc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    kind,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && (kind == KIND_QUERY)) state_next = S_RD_FIRST;
      end
      S_RD_FIRST:  state_next = S_CHK_FIRST;
      S_CHK_FIRST: state_next = status.below ? S_IDLE : S_CHK_LAST;
      S_CHK_LAST:  state_next = status.at_top ? S_IDLE : S_SCAN;
      S_SCAN: begin
        if (!status.at_top) state_next = S_MUL;
      end
      S_MUL:    state_next = S_DIV_GO;
      S_DIV_GO: state_next = S_DIV;
      S_DIV: begin
        if (status.div_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_ZERO;
    cmd.emit_range = RANGE_INTERP;
    unique case (state)
      S_IDLE: begin
        cmd.wr_en    = start && (kind == KIND_LOAD);
        cmd.query_go = start && (kind == KIND_QUERY);
      end
      S_RD_FIRST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
      end
      S_CHK_FIRST: begin
        if (status.below) begin
          cmd.emit       = 1'b1;
          cmd.emit_range = RANGE_BELOW;
        end else begin
          cmd.save_lo = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_LAST;
        end
      end
      S_CHK_LAST: begin
        if (status.at_top) begin
          cmd.emit       = 1'b1;
          cmd.emit_range = RANGE_ABOVE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_ONE;
          cmd.idx_init = 1'b1;
        end
      end
      S_SCAN: begin
        if (!status.at_top) begin
          cmd.save_hi = 1'b1;
        end else begin
          cmd.save_lo = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      S_MUL:    cmd.mul_go = 1'b1;
      S_DIV_GO: cmd.div_go = 1'b1;
      S_DIV: begin
        if (status.div_done) begin
          cmd.emit       = 1'b1;
          cmd.emit_range = RANGE_INTERP;
        end
      end
      default: ;
    endcase
  end

  // Result strobe is a single-cycle pulse per query
  a_emit_single: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !cmd.emit)
    else $error("result strobe held for two cycles");

  // An accepted query starts the table search
  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_QUERY)) |=> (state == S_RD_FIRST))
    else $error("query accepted but search not started");

  // Divider completes only while waiting for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide wait");

endmodule

FILE: sv/ocvsoc_dpath.sv
// Datapath: breakpoint memory, segment registers, multiplier, divider, result registers.
module ocvsoc_dpath
  import ocvsoc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic [IDX_W-1:0] entry_index,
  input  logic [OCV_W-1:0] entry_ocv,
  input  logic [SOC_W-1:0] entry_soc,
  input  logic [OCV_W-1:0] ocv_sample,
  output logic             done,
  output logic [SOC_W-1:0] soc_value,
  output logic [1:0]       range_status
);

  logic [ENTRY_W-1:0] mem [MAX_POINTS];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [OCV_W-1:0]   rd_ocv;
  logic [SOC_W-1:0]   rd_soc;

  logic [CFG_W-1:0]   table_size;
  logic [OCV_W-1:0]   v;
  logic [IDX_W-1:0]   last;
  logic [IDX_W-1:0]   idx;

  logic [OCV_W-1:0]   lo_ocv;
  logic [SOC_W-1:0]   lo_soc;
  logic [OCV_W-1:0]   hi_ocv;
  logic [SOC_W-1:0]   hi_soc;

  logic [OCV_W-1:0]   dv;
  logic [OCV_W-1:0]   dx;
  logic [SOC_W-1:0]   dy_mag;
  logic               dy_neg;

  logic [PROD_W-1:0]  prod;
  logic [OCV_W-1:0]   dx_reg;
  logic               neg;

  logic               div_done;
  logic [PROD_W-1:0]  quo;
  logic [SOC_W-1:0]   interp;

  assign rd_ocv = rd_data[ENTRY_W-1:SOC_W];
  assign rd_soc = rd_data[SOC_W-1:0];

  // Table size register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RST;
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_LAST: rd_addr = last;
      RD_ONE:  rd_addr = IDX_W'(1);
      RD_NEXT: rd_addr = idx + IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  // Breakpoint memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[entry_index] <= {entry_ocv, entry_soc};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Query sample, scan index and segment endpoints
  always_ff @(posedge clk) begin
    if (cmd.query_go) begin
      v    <= ocv_sample;
      last <= last_index(table_size);
    end
    if (cmd.idx_init) begin
      idx <= IDX_W'(1);
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.save_lo) begin
      lo_ocv <= rd_ocv;
      lo_soc <= rd_soc;
    end
    if (cmd.save_hi) begin
      hi_ocv <= rd_ocv;
      hi_soc <= rd_soc;
    end
  end

  // Status compares against the word just read
  assign status.below    = (v < rd_ocv);
  assign status.at_top   = (v >= rd_ocv);
  assign status.div_done = div_done;

  // Segment deltas
  assign dv     = v - lo_ocv;
  assign dx     = hi_ocv - lo_ocv;
  assign dy_neg = (hi_soc < lo_soc);
  assign dy_mag = dy_neg ? (lo_soc - hi_soc) : (hi_soc - lo_soc);

  // Product of offset and charge step magnitude
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod   <= PROD_W'(dv) * PROD_W'(dy_mag);
      dx_reg <= dx;
      neg    <= dy_neg;
    end
  end

  ocvsoc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (prod),
    .divisor  (dx_reg),
    .done     (div_done),
    .quotient (quo)
  );

  // Quotient is below the step magnitude, so it fits the charge width
  assign interp = neg ? (lo_soc - quo[SOC_W-1:0]) : (lo_soc + quo[SOC_W-1:0]);

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      range_status <= cmd.emit_range;
      if (cmd.emit_range == RANGE_INTERP) begin
        soc_value <= interp;
      end else begin
        soc_value <= rd_soc;
      end
    end
  end

  // Quotient never exceeds the charge width
  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (quo[PROD_W-1:SOC_W] == '0))
    else $error("quotient overflows charge width");

  // Upper endpoint of a found segment lies above the sample
  a_seg_upper: assert property (@(posedge clk) disable iff (rst)
    cmd.save_hi |=> (hi_ocv > v))
    else $error("segment upper breakpoint not above sample");

  // Lower endpoint never lies above the sample
  a_seg_lower: assert property (@(posedge clk) disable iff (rst)
    cmd.save_lo |=> (lo_ocv <= v))
    else $error("segment lower breakpoint above sample");

endmodule

FILE: sv/ocv_to_soc_interpolator.sv
// Top level of the OCV to state-of-charge interpolator.
//
// Input words are taken when start is high and busy is low. kind selects a
// load (write one voltage/charge breakpoint at entry_index) or a query
// (map ocv_sample to a charge). The table size register is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block is
// idle, as the block does not enforce this. Reset sets it to 16. Loads keep
// busy low and give no result word. A query raises busy the next cycle and
// ends with one result word on soc_value / range_status, marked by done for
// exactly one cycle. A query clamped below the first breakpoint ends after
// reading it, one clamped at or above the last after also reading the last.
// An interpolation in the segment that starts at breakpoint k (k from 0 to
// 14) then scans the table one entry per cycle through the single memory read
// port and runs the 30-step serial divider. One query is in flight at a time.
// The receiver cannot stall; done must be sampled when it is high.
// Reset (rst, synchronous) returns the controller to idle and clears done;
// the breakpoint table is not cleared and must be loaded before queries.
module ocv_to_soc_interpolator
  import ocvsoc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             kind,
  input  logic [IDX_W-1:0] entry_index,
  input  logic [OCV_W-1:0] entry_ocv,
  input  logic [SOC_W-1:0] entry_soc,
  input  logic [OCV_W-1:0] ocv_sample,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output logic             done,
  output logic [SOC_W-1:0] soc_value,
  output logic [1:0]       range_status
);

  cmd_t    cmd;
  status_t status;

  // Controller
  ocvsoc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath
  ocvsoc_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .entry_index  (entry_index),
    .entry_ocv    (entry_ocv),
    .entry_soc    (entry_soc),
    .ocv_sample   (ocv_sample),
    .done         (done),
    .soc_value    (soc_value),
    .range_status (range_status)
  );

endmodule
